// File: rtl/swmd_pkg.sv
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared constants, types and helpers for the sliding-window minimum delay
// tracker.
// ----------------------------------------------------------------------------
package swmd_pkg;

  localparam int unsigned STORE_DEPTH = 128;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;

  localparam logic [DATA_W-1:0] WINDOW_RESET = DATA_W'(120000);

  // Which store position a read is aimed at.
  typedef enum logic [2:0] {
    RD_HEAD,
    RD_HEAD_NEXT,
    RD_TAIL,
    RD_TAIL_PREV,
    RD_FRONT
  } rd_sel_e;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    pop_front;
    logic    pop_tail;
    logic    clear;
    logic    append;
    logic    load_out;
  } swmd_cmd_t;

  typedef struct packed {
    logic empty;
    logic one_left;
    logic expired;
    logic below_front;
    logic trim_hit;
    logic out_busy;
  } swmd_status_t;

  // Circular position: base plus offset, wrapped once into the store.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(STORE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(STORE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/sliding_window_min_delay_core.sv
// ----------------------------------------------------------------------------
// sliding_window_min_delay_core
// Minimum one-way delay over a sliding time window (base-delay estimator).
// ----------------------------------------------------------------------------
// Each input word carries a delay sample in microseconds and its arrival
// time in milliseconds; each produces exactly one output word with the
// minimum delay still inside the window and a flag set when the oldest entry
// was dropped because the 128-entry store was full.
// The window length is written through cfg_we_i/cfg_wdata_i; the user must do
// so only while the block is idle, the block itself does not enforce this; it resets to 120000 ms.
// Each word is accepted, then passes the front expiry walk and the tail trim
// walk, the append and the result hand-off; an empty store skips both walks,
// and the trim walk is skipped when expiry empties the store or the new delay
// is below the front entry. The walks step through the single-port-read entry
// memory one entry per cycle.
// A new input word is taken as soon as the previous one has been placed in
// the output register, even while that result waits; if the receiver still
// stalls when the next result is ready, the sequencer holds it and takes no
// further input. Reset empties the store at once (the entry memory itself is
// not cleared) and drops any pending result.
// ----------------------------------------------------------------------------
module sliding_window_min_delay_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swmd_pkg::DATA_W-1:0]   cfg_wdata_i,     // window_length
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [2*swmd_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] delay_us, [63:32] arrival_time
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [swmd_pkg::DATA_W-1:0]   m_axis_tdata_o,  // [31:0] base_delay
  output logic                          m_axis_tuser_o   // [0] overflowed
);

  swmd_pkg::swmd_cmd_t    cmd;
  swmd_pkg::swmd_status_t status;

  swmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swmd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

// File: rtl/swmd_datapath.sv
// ----------------------------------------------------------------------------
// swmd_datapath
// Circular entry store, head and fill count, window register, input capture
// and output register of the minimum delay tracker.
// ----------------------------------------------------------------------------
module swmd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swmd_pkg::DATA_W-1:0]   cfg_wdata_i,
  input  logic [2*swmd_pkg::DATA_W-1:0] in_data_i,   // delay_us, arrival_time
  input  swmd_pkg::swmd_cmd_t           cmd_i,
  output swmd_pkg::swmd_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [swmd_pkg::DATA_W-1:0]   out_data_o,  // base_delay
  output logic                          out_user_o   // overflowed
);

  localparam int unsigned DW = swmd_pkg::DATA_W;
  localparam int unsigned IW = swmd_pkg::IDX_W;
  localparam int unsigned CW = swmd_pkg::CNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(swmd_pkg::STORE_DEPTH);

  // Each entry holds the arrival time in the upper half, the delay below.
  logic [2*DW-1:0] mem_q [swmd_pkg::STORE_DEPTH];
  logic [2*DW-1:0] rdata_q;

  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] window_q;
  logic [DW-1:0] delay_q, time_q;
  logic          new_front_q, ovf_q;
  logic          out_valid_q;
  logic [DW-1:0] out_data_q;
  logic          out_user_q;

  logic          full;
  logic [CW-1:0] rd_off, wr_off;
  logic [IW-1:0] raddr, waddr;
  logic [DW-1:0] entry_delay, entry_time, age;

  assign full        = (count_q == FULL_CNT);
  assign entry_delay = rdata_q[DW-1:0];
  assign entry_time  = rdata_q[2*DW-1:DW];
  assign age         = time_q - entry_time;

  always_comb begin
    case (cmd_i.rd_sel)
      swmd_pkg::RD_HEAD:      rd_off = '0;
      swmd_pkg::RD_HEAD_NEXT: rd_off = CW'(1);
      swmd_pkg::RD_TAIL:      rd_off = count_q - CW'(1);
      swmd_pkg::RD_TAIL_PREV: rd_off = count_q - CW'(2);
      swmd_pkg::RD_FRONT:     rd_off = full ? CW'(1) : '0;
      default:                rd_off = '0;
    endcase
  end

  // With a full store the new entry takes the oldest slot, so the head moves.
  assign wr_off = full ? '0 : count_q;
  assign raddr  = swmd_pkg::wrap_add(head_q, rd_off);
  assign waddr  = swmd_pkg::wrap_add(head_q, wr_off);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[waddr] <= {time_q, delay_q};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.pop_front) begin
      head_d  = swmd_pkg::wrap_add(head_q, CW'(1));
      count_d = count_q - CW'(1);
    end else if (cmd_i.pop_tail) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.append) begin
      if (full) begin
        head_d = swmd_pkg::wrap_add(head_q, CW'(1));
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      window_q    <= swmd_pkg::WINDOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      delay_q <= in_data_i[DW-1:0];
      time_q  <= in_data_i[2*DW-1:DW];
    end
    if (cmd_i.append) begin
      new_front_q <= (count_q == '0);
      ovf_q       <= full;
    end
    if (cmd_i.load_out) begin
      out_data_q <= new_front_q ? delay_q : entry_delay;
      out_user_q <= ovf_q;
    end
  end

  assign status_o.empty       = (count_q == '0);
  assign status_o.one_left    = (count_q == CW'(1));
  assign status_o.expired     = (age > window_q);
  assign status_o.below_front = (delay_q < entry_delay);
  assign status_o.trim_hit    = (entry_delay >= delay_q);
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("fill count beyond store depth");

  a_pop_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_front || cmd_i.pop_tail) |-> count_q != '0)
    else $error("entry removed from an empty store");

  a_append_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.append && !full) |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not grow the store");

  a_full_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.append && full) |=> count_q == FULL_CNT && ovf_q)
    else $error("append to a full store lost its count or flag");

endmodule

// File: rtl/swmd_ctrl.sv
// ----------------------------------------------------------------------------
// swmd_ctrl
// Sequencer for the minimum delay tracker: front expiry walk, tail trim walk,
// append and result hand-off.
// ----------------------------------------------------------------------------
module swmd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  swmd_pkg::swmd_status_t status_i,
  output swmd_pkg::swmd_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPIRE = 3'd1;
  localparam logic [2:0] ST_TRIM   = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = swmd_pkg::RD_HEAD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cmd_o.rd_en   = 1'b1;
          state_d = status_i.empty ? ST_WRITE : ST_EXPIRE;
        end
      end
      // The read data holds the current front entry.
      ST_EXPIRE: begin
        if (status_i.expired) begin
          cmd_o.pop_front = 1'b1;
          if (status_i.one_left) begin
            state_d = ST_WRITE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = swmd_pkg::RD_HEAD_NEXT;
          end
        end else if (status_i.below_front) begin
          cmd_o.clear = 1'b1;
          state_d = ST_WRITE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = swmd_pkg::RD_TAIL;
          state_d = ST_TRIM;
        end
      end
      // The read data holds the current tail entry.
      ST_TRIM: begin
        if (status_i.trim_hit) begin
          cmd_o.pop_tail = 1'b1;
          if (status_i.one_left) begin
            state_d = ST_WRITE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = swmd_pkg::RD_TAIL_PREV;
          end
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.append = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = swmd_pkg::RD_FRONT;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_result_per_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.append |=> cmd_o.load_out || state_q == ST_RESULT)
    else $error("append not followed by a result");

endmodule
